// ===== rtl/tbgc_pkg.sv =====
// Package: shared types and constants of the two-blob gesture classifier.
package tbgc_pkg;

  localparam int FRAME_WIDTH   = 640;
  localparam int FRAME_HEIGHT  = 360;
  localparam int SCREEN_WIDTH  = 1440;
  localparam int SCREEN_HEIGHT = 900;
  localparam int EDGE_MARGIN   = 15;
  localparam int EDGE_PUSH     = 7;
  localparam int TRAVEL_BASE   = 100;

  // Screen scaling as an exact ratio: multiply, then shift right.
  localparam int SX_SHIFT = 2;
  localparam int SX_MUL   = SCREEN_WIDTH * (1 << SX_SHIFT) / FRAME_WIDTH;
  localparam int SY_SHIFT = 1;
  localparam int SY_MUL   = SCREEN_HEIGHT * (1 << SY_SHIFT) / FRAME_HEIGHT;

  localparam int AREA_W = 26;
  localparam int SUM_W  = 35;
  localparam int POS_W  = 10;
  localparam int CNT_W  = $clog2(SUM_W + 1);
  localparam int CFG_W  = 26;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_SWIPE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRESENT = 3'd1;
  localparam logic [IDX_W-1:0] REG_ABSENT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SHRINK  = 3'd3;
  localparam logic [IDX_W-1:0] REG_GROW    = 3'd4;
  localparam logic [IDX_W-1:0] REG_BLANK   = 3'd5;

  localparam logic [2:0] GEST_NONE  = 3'd0;
  localparam logic [2:0] GEST_RIGHT = 3'd1;
  localparam logic [2:0] GEST_LEFT  = 3'd2;
  localparam logic [2:0] GEST_SHRINK = 3'd3;
  localparam logic [2:0] GEST_GROW  = 3'd4;
  localparam logic [2:0] GEST_MOVE  = 3'd5;

  // Which quotient the divider is computing.
  typedef enum logic [1:0] {
    DIV_RX = 2'd0,
    DIV_GX = 2'd1,
    DIV_GY = 2'd2
  } div_sel_t;

  // Frame classification.
  typedef enum logic [1:0] {
    CASE_RED   = 2'd0,
    CASE_BOTH  = 2'd1,
    CASE_GREEN = 2'd2,
    CASE_BLANK = 2'd3
  } frame_case_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     update;
  } tbgc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic        div_done;
    frame_case_t fcase;
  } tbgc_stat_t;

endpackage

// ===== rtl/tbgc_divider.sv =====
// Bit-serial restoring divider for one moment over an area, with saturation.
module tbgc_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tbgc_pkg::SUM_W-1:0] dividend,
  input  logic [tbgc_pkg::AREA_W-1:0] divisor,
  input  logic [tbgc_pkg::POS_W-1:0] limit_m1,
  output logic                       done,
  output logic [tbgc_pkg::POS_W-1:0] quotient
);

  logic [tbgc_pkg::SUM_W-1:0]  quo_r, quo_nxt;
  logic [tbgc_pkg::AREA_W:0]   rem_r, rem_nxt;
  logic [tbgc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [tbgc_pkg::AREA_W:0]   trial;
  logic [tbgc_pkg::AREA_W:0]   shifted;

  // One quotient bit per cycle, most significant first.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[tbgc_pkg::AREA_W-1:0], quo_r[tbgc_pkg::SUM_W-1]};
    trial    = shifted - {1'b0, divisor};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = tbgc_pkg::CNT_W'(tbgc_pkg::SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, divisor}) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[tbgc_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[tbgc_pkg::SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == tbgc_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // A zero area gives zero; a quotient past the frame saturates.
  always_comb begin
    if (divisor == '0) begin
      quotient = '0;
    end else if (quo_r > tbgc_pkg::SUM_W'(limit_m1)) begin
      quotient = limit_m1;
    end else begin
      quotient = quo_r[tbgc_pkg::POS_W-1:0];
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/tbgc_datapath.sv =====
// Datapath: configuration and frame registers, centroid divider, tracking state and result register.
module tbgc_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tbgc_pkg::tbgc_cmd_t         cmd,
  output tbgc_pkg::tbgc_stat_t        stat,
  input  logic [tbgc_pkg::AREA_W-1:0] red_area,
  input  logic [tbgc_pkg::SUM_W-1:0]  red_sum_x,
  input  logic [tbgc_pkg::AREA_W-1:0] green_area,
  input  logic [tbgc_pkg::SUM_W-1:0]  green_sum_x,
  input  logic [tbgc_pkg::SUM_W-2:0]  green_sum_y,
  input  logic                        cfg_we,
  input  logic [tbgc_pkg::IDX_W-1:0]  cfg_addr,
  input  logic [tbgc_pkg::CFG_W-1:0]  cfg_wdata,
  output logic [2:0]                  gesture,
  output logic signed [11:0]          pointer_x,
  output logic signed [10:0]          pointer_y
);

  // Configuration registers.
  logic [8:0]                  swipe_r;
  logic [tbgc_pkg::AREA_W-1:0] present_r, absent_r;
  logic [3:0]                  shrink_frm_r, grow_frm_r, blank_frm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swipe_r      <= 9'd175;
      present_r    <= 26'd10000;
      absent_r     <= 26'd1000;
      shrink_frm_r <= 4'd5;
      grow_frm_r   <= 4'd6;
      blank_frm_r  <= 4'd10;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tbgc_pkg::REG_SWIPE:   swipe_r      <= cfg_wdata[8:0];
        tbgc_pkg::REG_PRESENT: present_r    <= cfg_wdata;
        tbgc_pkg::REG_ABSENT:  absent_r     <= cfg_wdata;
        tbgc_pkg::REG_SHRINK:  shrink_frm_r <= cfg_wdata[3:0];
        tbgc_pkg::REG_GROW:    grow_frm_r   <= cfg_wdata[3:0];
        tbgc_pkg::REG_BLANK:   blank_frm_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Frame word capture.
  logic [tbgc_pkg::AREA_W-1:0] ra_r, ga_r;
  logic [tbgc_pkg::SUM_W-1:0]  rsx_r, gsx_r;
  logic [tbgc_pkg::SUM_W-2:0]  gsy_r;
  tbgc_pkg::frame_case_t       fcase_r;
  tbgc_pkg::frame_case_t       fcase_nxt;
  logic r_pres, r_abs, g_pres, g_abs;

  always_comb begin
    r_pres = red_area > present_r;
    r_abs  = red_area < absent_r;
    g_pres = green_area > present_r;
    g_abs  = green_area < absent_r;
    if (r_pres && g_abs)       fcase_nxt = tbgc_pkg::CASE_RED;
    else if (r_pres && g_pres) fcase_nxt = tbgc_pkg::CASE_BOTH;
    else if (g_pres && r_abs)  fcase_nxt = tbgc_pkg::CASE_GREEN;
    else                       fcase_nxt = tbgc_pkg::CASE_BLANK;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ra_r    <= red_area;
      ga_r    <= green_area;
      rsx_r   <= red_sum_x;
      gsx_r   <= green_sum_x;
      gsy_r   <= green_sum_y;
      fcase_r <= fcase_nxt;
    end
  end

  // Shared divider, operands picked by the controller.
  logic [tbgc_pkg::SUM_W-1:0]  div_num;
  logic [tbgc_pkg::AREA_W-1:0] div_den;
  logic [tbgc_pkg::POS_W-1:0]  div_lim;
  logic [tbgc_pkg::POS_W-1:0]  div_q;
  logic                        div_done;

  always_comb begin
    unique case (cmd.div_sel)
      tbgc_pkg::DIV_RX: begin
        div_num = rsx_r; div_den = ra_r;
        div_lim = tbgc_pkg::POS_W'(tbgc_pkg::FRAME_WIDTH - 1);
      end
      tbgc_pkg::DIV_GX: begin
        div_num = gsx_r; div_den = ga_r;
        div_lim = tbgc_pkg::POS_W'(tbgc_pkg::FRAME_WIDTH - 1);
      end
      default: begin
        div_num = {1'b0, gsy_r}; div_den = ga_r;
        div_lim = tbgc_pkg::POS_W'(tbgc_pkg::FRAME_HEIGHT - 1);
      end
    endcase
  end

  tbgc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .limit_m1 (div_lim),
    .done     (div_done),
    .quotient (div_q)
  );

  // Centroid capture as each division finishes.
  logic [tbgc_pkg::POS_W-1:0] rx_r, gx_r, gy_r;
  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (cmd.div_sel)
        tbgc_pkg::DIV_RX: rx_r <= div_q;
        tbgc_pkg::DIV_GX: gx_r <= div_q;
        default:          gy_r <= div_q;
      endcase
    end
  end

  assign stat.div_done = div_done;
  assign stat.fcase    = fcase_r;

  // Tracking state.
  logic [9:0]  prev_x_r, prev_x_nxt;
  logic        pvalid_r, pvalid_nxt;
  logic [10:0] rtrav_r, rtrav_nxt, ltrav_r, ltrav_nxt;
  logic [9:0]  pspread_r, pspread_nxt;
  logic [3:0]  srun_r, srun_nxt, grun_r, grun_nxt, brun_r, brun_nxt;
  logic        half_r, half_nxt;
  logic signed [12:0] psx_r, psx_nxt;
  logic signed [11:0] psy_r, psy_nxt;
  logic [2:0]  gest_r, gest_nxt;
  logic signed [11:0] px_r, px_nxt;
  logic signed [10:0] py_r, py_nxt;

  logic [11:0] tsum;
  logic [9:0]  thr;
  logic [9:0]  spread;
  logic signed [11:0] gxp, gyp;
  logic signed [11:0] dx;
  logic signed [14:0] mx;
  logic signed [12:0] my;
  logic signed [12:0] sx;
  logic signed [11:0] sy;
  logic signed [12:0] nsx;
  logic signed [11:0] nsy;

  always_comb begin
    prev_x_nxt  = prev_x_r;
    pvalid_nxt  = pvalid_r;
    rtrav_nxt   = rtrav_r;
    ltrav_nxt   = ltrav_r;
    pspread_nxt = pspread_r;
    srun_nxt    = srun_r;
    grun_nxt    = grun_r;
    brun_nxt    = brun_r;
    half_nxt    = half_r;
    psx_nxt     = psx_r;
    psy_nxt     = psy_r;
    gest_nxt    = tbgc_pkg::GEST_NONE;
    px_nxt      = '0;
    py_nxt      = '0;
    thr    = 10'(swipe_r) + 10'(tbgc_pkg::TRAVEL_BASE);
    tsum   = '0;
    spread = (rx_r > gx_r) ? rx_r - gx_r : gx_r - rx_r;
    // Edge push of the green centroid, then screen scaling.
    gxp = 12'(gx_r);
    if (gxp > 12'(tbgc_pkg::FRAME_WIDTH - tbgc_pkg::EDGE_MARGIN))
      gxp = gxp + 12'(tbgc_pkg::EDGE_PUSH);
    else if (gxp < 12'(tbgc_pkg::EDGE_MARGIN))
      gxp = gxp - 12'(tbgc_pkg::EDGE_PUSH);
    gyp = 12'(gy_r);
    if (gyp > 12'(tbgc_pkg::FRAME_HEIGHT - tbgc_pkg::EDGE_MARGIN))
      gyp = gyp + 12'(tbgc_pkg::EDGE_PUSH);
    else if (gyp < 12'(tbgc_pkg::EDGE_MARGIN))
      gyp = gyp - 12'(tbgc_pkg::EDGE_PUSH);
    dx  = 12'(tbgc_pkg::FRAME_WIDTH) - gxp;
    // Scale by the ratio, then shift with a bias so negatives truncate toward zero.
    mx  = 15'(dx) * 15'(tbgc_pkg::SX_MUL);
    my  = 13'(gyp) * 13'(tbgc_pkg::SY_MUL);
    sx  = 13'((mx + (mx[14] ? 15'((1 << tbgc_pkg::SX_SHIFT) - 1) : 15'sd0))
              >>> tbgc_pkg::SX_SHIFT);
    sy  = 12'((my + (my[12] ? 13'((1 << tbgc_pkg::SY_SHIFT) - 1) : 13'sd0))
              >>> tbgc_pkg::SY_SHIFT);
    nsx = psx_r + sx;
    nsy = psy_r + sy;

    unique case (fcase_r)
      tbgc_pkg::CASE_RED: begin
        if (pvalid_r) begin
          if (prev_x_r > rx_r) begin
            ltrav_nxt = '0;
            tsum = 12'(rtrav_r) + 12'(prev_x_r - rx_r);
            rtrav_nxt = tsum[11] ? 11'h7FF : tsum[10:0];
            if (rtrav_nxt >= 11'(thr)) begin
              gest_nxt  = tbgc_pkg::GEST_RIGHT;
              rtrav_nxt = '0;
            end
          end else if (prev_x_r < rx_r) begin
            rtrav_nxt = '0;
            tsum = 12'(ltrav_r) + 12'(rx_r - prev_x_r);
            ltrav_nxt = tsum[11] ? 11'h7FF : tsum[10:0];
            if (ltrav_nxt >= 11'(thr)) begin
              gest_nxt  = tbgc_pkg::GEST_LEFT;
              ltrav_nxt = '0;
            end
          end
        end
        prev_x_nxt = rx_r;
        pvalid_nxt = 1'b1;
      end
      tbgc_pkg::CASE_BOTH: begin
        if (spread < pspread_r) begin
          srun_nxt = srun_r + 4'd1;
          grun_nxt = '0;
          pspread_nxt = spread;
          if (srun_nxt >= shrink_frm_r) begin
            srun_nxt = '0;
            gest_nxt = tbgc_pkg::GEST_SHRINK;
          end
        end else if (spread > pspread_r) begin
          grun_nxt = grun_r + 4'd1;
          srun_nxt = '0;
          pspread_nxt = spread;
          if (grun_nxt >= grow_frm_r) begin
            grun_nxt = '0;
            gest_nxt = tbgc_pkg::GEST_GROW;
          end
        end
        prev_x_nxt = rx_r;
        pvalid_nxt = 1'b1;
      end
      tbgc_pkg::CASE_GREEN: begin
        half_nxt = ~half_r;
        if (half_r) begin
          gest_nxt = tbgc_pkg::GEST_MOVE;
          px_nxt   = 12'(nsx / 13'sd2);
          py_nxt   = 11'(nsy / 12'sd2);
          psx_nxt  = '0;
          psy_nxt  = '0;
        end else begin
          psx_nxt = nsx;
          psy_nxt = nsy;
        end
      end
      default: begin
        brun_nxt = brun_r + 4'd1;
        if (brun_nxt == blank_frm_r) begin
          rtrav_nxt  = '0;
          ltrav_nxt  = '0;
          brun_nxt   = '0;
          pvalid_nxt = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r  <= '0;
      pvalid_r  <= 1'b0;
      rtrav_r   <= '0;
      ltrav_r   <= '0;
      pspread_r <= '0;
      srun_r    <= '0;
      grun_r    <= '0;
      brun_r    <= '0;
      half_r    <= 1'b0;
      psx_r     <= '0;
      psy_r     <= '0;
    end else if (cmd.update) begin
      prev_x_r  <= prev_x_nxt;
      pvalid_r  <= pvalid_nxt;
      rtrav_r   <= rtrav_nxt;
      ltrav_r   <= ltrav_nxt;
      pspread_r <= pspread_nxt;
      srun_r    <= srun_nxt;
      grun_r    <= grun_nxt;
      brun_r    <= brun_nxt;
      half_r    <= half_nxt;
      psx_r     <= psx_nxt;
      psy_r     <= psy_nxt;
    end
  end

  // Result register, held until the output word is taken.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      gest_r <= gest_nxt;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
    end
  end

  assign gesture   = gest_r;
  assign pointer_x = px_r;
  assign pointer_y = py_r;

endmodule

// ===== rtl/tbgc_ctrl.sv =====
// Controller: sequences capture, the centroid divisions, the update and the output word.
module tbgc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output tbgc_pkg::tbgc_cmd_t  cmd,
  input  tbgc_pkg::tbgc_stat_t stat
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_NEXT  = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  tbgc_pkg::div_sel_t  sel_r, sel_nxt;
  logic                last_div;

  // Which divisions a case needs.
  always_comb begin
    unique case (stat.fcase)
      tbgc_pkg::CASE_RED:  last_div = (sel_r == tbgc_pkg::DIV_RX);
      tbgc_pkg::CASE_BOTH: last_div = (sel_r == tbgc_pkg::DIV_GX);
      default:             last_div = (sel_r == tbgc_pkg::DIV_GY);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = sel_r;
    cmd.update    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (stat.fcase == tbgc_pkg::CASE_BLANK) begin
          state_nxt = ST_UPD;
        end else begin
          sel_nxt   = (stat.fcase == tbgc_pkg::CASE_GREEN) ? tbgc_pkg::DIV_GX
                                                            : tbgc_pkg::DIV_RX;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          if (last_div) begin
            state_nxt = ST_UPD;
          end else begin
            sel_nxt   = (sel_r == tbgc_pkg::DIV_RX) ? tbgc_pkg::DIV_GX
                                                     : tbgc_pkg::DIV_GY;
            state_nxt = ST_NEXT;
          end
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= tbgc_pkg::DIV_RX;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);

endmodule

// ===== rtl/two_blob_gesture_classifier.sv =====
// Top level of the two-blob gesture classifier: ports, controller and datapath.
//
//  Channel | Direction | Word
//  in_     | input     | tdata: red_area, red_sum_x, red_sum_y, green_area,
//          |           |        green_sum_x, green_sum_y (190 bits, 192 wide)
//  out_    | output    | tdata: gesture, pointer_x, pointer_y (26 bits, 32 wide)
//  cfg_    | input     | write-only register port, index 0..5
//
// A blank frame needs no division, a red-only frame needs one and a frame with both colors
// or green only needs two; the serial divider gives one quotient bit per cycle over 35 bits.
// The result word is then held until the receiver takes it.
// Reset is synchronous on rst_n and restores control, configuration and tracking registers only.
// A new word is taken only after the previous result word has been taken.
module two_blob_gesture_classifier (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // red_area[25:0], red_sum_x[60:26], red_sum_y[94:61], green_area[120:95],
  // green_sum_x[155:121], green_sum_y[189:156], zero fill
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // gesture[2:0], pointer_x[14:3], pointer_y[25:15], zero fill
  output logic [31:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [25:0]  cfg_wdata
);

  tbgc_pkg::tbgc_cmd_t  cmd;
  tbgc_pkg::tbgc_stat_t stat;
  logic [2:0]           gesture;
  logic signed [11:0]   pointer_x;
  logic signed [10:0]   pointer_y;

  tbgc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // red_sum_y is not used by any case.
  tbgc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .red_area    (in_tdata[25:0]),
    .red_sum_x   (in_tdata[60:26]),
    .green_area  (in_tdata[120:95]),
    .green_sum_x (in_tdata[155:121]),
    .green_sum_y (in_tdata[189:156]),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .gesture     (gesture),
    .pointer_x   (pointer_x),
    .pointer_y   (pointer_y)
  );

  assign out_tdata = {6'd0, pointer_y, pointer_x, gesture};

endmodule

// ===== bench/tb_two_blob_gesture_classifier.sv =====
// Testbench of the two-blob gesture classifier: directed and random frames against a predictor.
`timescale 1ns / 1ps

module tb_two_blob_gesture_classifier;

  // Frame moments of one word.
  typedef struct {
    logic [25:0] r_area;
    logic [34:0] r_sx;
    logic [33:0] r_sy;
    logic [25:0] g_area;
    logic [34:0] g_sx;
    logic [33:0] g_sy;
  } frame_t;

  // Classification of one word.
  typedef struct packed {
    logic [10:0] py;
    logic [11:0] px;
    logic [2:0]  gesture;
  } verdict_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [191:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [25:0]  cfg_wdata;

  two_blob_gesture_classifier i_dut (.*);

  // Predictor configuration.
  int unsigned swipe_sens, present_thr, absent_thr, shrink_need, grow_need, blank_need;
  // Predictor state.
  int unsigned last_rx, right_trav, left_trav, last_spread, shrink_cnt, grow_cnt, blank_cnt;
  bit          last_rx_ok, odd_pointer;
  int          acc_x, acc_y;

  verdict_t expected_verdicts[$];
  int       fail_count;
  bit       hold_off;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL two_blob_gesture_classifier");
    $finish;
  end

  function automatic int unsigned centroid_of(logic [34:0] s, logic [25:0] a, int unsigned lim);
    longint unsigned q;
    if (a == 0) return 0;
    q = longint'(s) / longint'(a);
    if (q > lim - 1) q = lim - 1;
    return int'(q);
  endfunction

  function automatic int pushed(int v, int size);
    if (v > size - tbgc_pkg::EDGE_MARGIN) return v + tbgc_pkg::EDGE_PUSH;
    if (v < tbgc_pkg::EDGE_MARGIN) return v - tbgc_pkg::EDGE_PUSH;
    return v;
  endfunction

  function automatic int unsigned sat_travel(int unsigned t, int unsigned d);
    return (t + d > 2047) ? 2047 : t + d;
  endfunction

  // Work out the classification of one frame and advance the predictor state.
  function automatic verdict_t classify(frame_t f);
    verdict_t v;
    bit rp, ra, gp, ga;
    int unsigned rx, gx, spr, thr;
    int sx, sy, gxs, gys;
    v = '0;
    rp = f.r_area > present_thr;
    ra = f.r_area < absent_thr;
    gp = f.g_area > present_thr;
    ga = f.g_area < absent_thr;
    if (rp && ga) begin
      rx = centroid_of(f.r_sx, f.r_area, tbgc_pkg::FRAME_WIDTH);
      thr = swipe_sens + tbgc_pkg::TRAVEL_BASE;
      if (last_rx_ok) begin
        if (last_rx > rx) begin
          left_trav = 0;
          right_trav = sat_travel(right_trav, last_rx - rx);
          if (right_trav >= thr) begin
            v.gesture = tbgc_pkg::GEST_RIGHT;
            right_trav = 0;
          end
        end else if (last_rx < rx) begin
          right_trav = 0;
          left_trav = sat_travel(left_trav, rx - last_rx);
          if (left_trav >= thr) begin
            v.gesture = tbgc_pkg::GEST_LEFT;
            left_trav = 0;
          end
        end
      end
      last_rx = rx;
      last_rx_ok = 1;
    end else if (rp && gp) begin
      rx = centroid_of(f.r_sx, f.r_area, tbgc_pkg::FRAME_WIDTH);
      gx = centroid_of(f.g_sx, f.g_area, tbgc_pkg::FRAME_WIDTH);
      spr = rx > gx ? rx - gx : gx - rx;
      if (spr < last_spread) begin
        shrink_cnt = (shrink_cnt + 1) & 15;
        grow_cnt = 0;
        last_spread = spr;
        if (shrink_cnt >= shrink_need) begin
          shrink_cnt = 0;
          v.gesture = tbgc_pkg::GEST_SHRINK;
        end
      end else if (spr > last_spread) begin
        grow_cnt = (grow_cnt + 1) & 15;
        shrink_cnt = 0;
        last_spread = spr;
        if (grow_cnt >= grow_need) begin
          grow_cnt = 0;
          v.gesture = tbgc_pkg::GEST_GROW;
        end
      end
      last_rx = rx;
      last_rx_ok = 1;
    end else if (gp && ra) begin
      gxs = pushed(int'(centroid_of(f.g_sx, f.g_area, tbgc_pkg::FRAME_WIDTH)),
                   tbgc_pkg::FRAME_WIDTH);
      gys = pushed(int'(centroid_of({1'b0, f.g_sy}, f.g_area, tbgc_pkg::FRAME_HEIGHT)),
                   tbgc_pkg::FRAME_HEIGHT);
      sx = ((tbgc_pkg::FRAME_WIDTH - gxs) * tbgc_pkg::SCREEN_WIDTH) / tbgc_pkg::FRAME_WIDTH;
      sy = (gys * tbgc_pkg::SCREEN_HEIGHT) / tbgc_pkg::FRAME_HEIGHT;
      acc_x += sx;
      acc_y += sy;
      odd_pointer = ~odd_pointer;
      if (!odd_pointer) begin
        v.gesture = tbgc_pkg::GEST_MOVE;
        v.px = 12'(acc_x / 2);
        v.py = 11'(acc_y / 2);
        acc_x = 0;
        acc_y = 0;
      end
    end else begin
      blank_cnt = (blank_cnt + 1) & 15;
      if (blank_cnt == blank_need) begin
        right_trav = 0;
        left_trav = 0;
        blank_cnt = 0;
        last_rx_ok = 0;
      end
    end
    return v;
  endfunction

  // Send one frame word after a random gap; valid stays high when there is no gap.
  task automatic send_frame(frame_t f);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {2'b0, f.g_sy, f.g_sx, f.g_area, f.r_sy, f.r_sx, f.r_area};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_verdicts.push_back(classify(f));
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 5);
      if (hold_off) begin
        gap = 400;
        hold_off = 0;
      end
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Result checker: compare each word taken with the oldest expectation.
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[25:0];
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (got.gesture !== want.gesture) begin
          $display("%0t: gesture expected %0d actual %0d", $time, want.gesture, got.gesture);
          fail_count++;
        end
        if (got.px !== want.px) begin
          $display("%0t: pointer_x expected %h actual %h", $time, want.px, got.px);
          fail_count++;
        end
        if (got.py !== want.py) begin
          $display("%0t: pointer_y expected %h actual %h", $time, want.py, got.py);
          fail_count++;
        end
      end
    end
  end

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Write one register and mirror it in the predictor.
  task automatic write_reg(logic [2:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= 26'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      tbgc_pkg::REG_SWIPE:   swipe_sens = val & 'h1FF;
      tbgc_pkg::REG_PRESENT: present_thr = val & 'h3FFFFFF;
      tbgc_pkg::REG_ABSENT:  absent_thr = val & 'h3FFFFFF;
      tbgc_pkg::REG_SHRINK:  shrink_need = val & 15;
      tbgc_pkg::REG_GROW:    grow_need = val & 15;
      tbgc_pkg::REG_BLANK:   blank_need = val & 15;
      default: ;
    endcase
  endtask

  // One blob at centroid (x, y) of the given area.
  function automatic void blob(int unsigned area, int unsigned x, int unsigned y,
                               output logic [25:0] a, output logic [34:0] sx,
                               output logic [33:0] sy);
    a = 26'(area);
    sx = 35'(longint'(area) * x + $urandom_range(0, area > 0 ? area - 1 : 0));
    sy = 34'(longint'(area) * y);
  endfunction

  function automatic frame_t make_frame(int unsigned ra, int unsigned rx,
                                        int unsigned ga, int unsigned gx, int unsigned gy);
    frame_t f;
    blob(ra, rx, $urandom_range(0, 359), f.r_area, f.r_sx, f.r_sy);
    blob(ga, gx, gy, f.g_area, f.g_sx, f.g_sy);
    return f;
  endfunction

  function automatic frame_t noise_frame();
    frame_t f;
    f.r_area = 26'($urandom);
    f.r_sx = 35'({$urandom, $urandom});
    f.r_sy = 34'({$urandom, $urandom});
    f.g_area = 26'($urandom);
    f.g_sx = 35'({$urandom, $urandom});
    f.g_sy = 34'({$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) f.r_area = 0;
    if ($urandom_range(0, 3) == 0) f.g_area = 0;
    return f;
  endfunction

  function automatic int unsigned big_area();
    return $urandom_range(0, 7) == 0 ? 58752000 : $urandom_range(10001, 200000);
  endfunction

  // Directed extremes and each case.
  task automatic test_directed;
    frame_t f;
    send_frame(make_frame(0, 0, 0, 0, 0));
    send_frame(make_frame(58752000, 639, 0, 0, 0));
    send_frame(make_frame(58752000, 0, 0, 0, 0));
    send_frame(make_frame(20000, 639, 0, 0, 0));
    send_frame(make_frame(20000, 639, 0, 0, 0));
    send_frame(make_frame(20000, 300, 20000, 100, 0));
    send_frame(make_frame(20000, 300, 20000, 290, 0));
    send_frame(make_frame(0, 0, 20000, 0, 0));
    send_frame(make_frame(0, 0, 20000, 639, 359));
    send_frame(make_frame(0, 0, 20000, 14, 346));
    send_frame(make_frame(0, 0, 20000, 626, 15));
    send_frame(make_frame(10000, 0, 10000, 0, 0));
    send_frame(make_frame(999, 0, 10001, 320, 180));
    send_frame(make_frame(1000, 0, 10001, 320, 180));
    // Centroid saturation from oversized moments.
    f.r_area = 20000; f.r_sx = '1; f.r_sy = '1;
    f.g_area = 20000; f.g_sx = '1; f.g_sy = '1;
    send_frame(f);
    f.r_area = 0;
    send_frame(f);
    send_frame(f);
    drain();
  endtask

  // Well-formed gesture sequences with random content, plus noise.
  task automatic test_random(int n);
    int unsigned x, g, k;
    repeat (n) begin
      k = $urandom_range(0, 9);
      x = $urandom_range(0, 639);
      if (k < 3) begin
        send_frame(make_frame(big_area(), x, $urandom_range(0, 999), 0, 0));
      end else if (k < 5) begin
        g = $urandom_range(0, 639);
        send_frame(make_frame(big_area(), x, big_area(), g, 0));
      end else if (k < 7) begin
        send_frame(make_frame($urandom_range(0, 999), 0, big_area(), x, $urandom_range(0, 359)));
      end else if (k < 8) begin
        send_frame(make_frame($urandom_range(0, 999), 0, $urandom_range(0, 999), 0, 0));
      end else begin
        send_frame(noise_frame());
      end
    end
    drain();
  endtask

  // Steady sweeps so swipes, pinches and grows actually fire.
  task automatic test_sweeps;
    int unsigned x;
    repeat (3) begin
      x = 0;
      repeat (12) begin
        send_frame(make_frame(50000, x, 0, 0, 0));
        x = (x + $urandom_range(20, 80)) % 640;
      end
      x = 630;
      repeat (20) begin
        send_frame(make_frame(50000, 320, 50000, x, 0));
        x = x > 20 ? x - $urandom_range(1, 20) : 630;
      end
      repeat (20) begin
        send_frame(make_frame(50000, 320, 50000, x, 0));
        x = x < 620 ? x + $urandom_range(1, 20) : 0;
      end
    end
    drain();
  endtask

  // Receiver stalls long while frames keep coming.
  task automatic test_backpressure;
    hold_off = 1;
    test_random(20);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = tbgc_pkg::REG_SWIPE;
    cfg_wdata = '0;
    fail_count = 0;
    hold_off = 0;
    swipe_sens = 175; present_thr = 10000; absent_thr = 1000;
    shrink_need = 5; grow_need = 6; blank_need = 10;
    last_rx = 0; last_rx_ok = 0; right_trav = 0; left_trav = 0; last_spread = 0;
    shrink_cnt = 0; grow_cnt = 0; blank_cnt = 0; odd_pointer = 0; acc_x = 0; acc_y = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_sweeps();
    test_random(120);
    test_backpressure();
    // Low extremes of every register.
    write_reg(tbgc_pkg::REG_SWIPE, 0);
    write_reg(tbgc_pkg::REG_PRESENT, 0);
    write_reg(tbgc_pkg::REG_ABSENT, 0);
    write_reg(tbgc_pkg::REG_SHRINK, 1);
    write_reg(tbgc_pkg::REG_GROW, 1);
    write_reg(tbgc_pkg::REG_BLANK, 1);
    test_sweeps();
    test_random(90);
    // High extremes, all ones in each register word but the blank count, which is set to zero.
    write_reg(tbgc_pkg::REG_SWIPE, 511);
    write_reg(tbgc_pkg::REG_PRESENT, 'h3FFFFFF);
    write_reg(tbgc_pkg::REG_ABSENT, 'h3FFFFFF);
    write_reg(tbgc_pkg::REG_SHRINK, 15);
    write_reg(tbgc_pkg::REG_GROW, 15);
    write_reg(tbgc_pkg::REG_BLANK, 0);
    test_random(50);
    // Mid settings.
    write_reg(tbgc_pkg::REG_SWIPE, 400);
    write_reg(tbgc_pkg::REG_PRESENT, 20000);
    write_reg(tbgc_pkg::REG_ABSENT, 5000);
    write_reg(tbgc_pkg::REG_SHRINK, 3);
    write_reg(tbgc_pkg::REG_GROW, 2);
    write_reg(tbgc_pkg::REG_BLANK, 4);
    test_sweeps();
    test_random(90);

    if (fail_count == 0) begin
      $display("PASS two_blob_gesture_classifier");
    end else begin
      $display("FAIL two_blob_gesture_classifier");
    end
    $finish;
  end

endmodule
